/* sv/quadrature_encoder_counter_macros.svh */
// Assertion macros shared by the quadrature encoder counter RTL.
`ifndef QUADRATURE_ENCODER_COUNTER_MACROS_SVH
`define QUADRATURE_ENCODER_COUNTER_MACROS_SVH

// Check a property on every rising clk edge, skipped while in reset.
`define QEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication whose consequent starts in the cycle after the antecedent.
`define QEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/qec_pkg.sv */
// Types, constants and the Gray-code step table of the quadrature encoder counter.
`timescale 1ns / 1ps
`default_nettype none
package qec_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned ACC_W   = 3;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    localparam logic [ACC_W-1:0]   ACC_REST    = 3'd4;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd60000;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic               pin_a;
        logic               pin_b;
        logic [COUNT_W-1:0] load_value;
    } item_t;

    typedef struct packed {
        logic [1:0]         prev_pins;
        logic [ACC_W-1:0]   acc;
        logic [COUNT_W-1:0] count;
    } state_t;

    // Forward: 0->1->3->2->0, backward the reverse; anything else is no step.
    function automatic logic [1:0] step_dir(input logic [1:0] from, input logic [1:0] to);
        logic [1:0] fwd;
        logic [1:0] back;
        unique case (from)
            2'd0: begin fwd = 2'd1; back = 2'd2; end
            2'd1: begin fwd = 2'd3; back = 2'd0; end
            2'd2: begin fwd = 2'd0; back = 2'd3; end
            default: begin fwd = 2'd2; back = 2'd1; end
        endcase
        if (to == fwd) begin
            return DIR_FWD;
        end
        if (to == back) begin
            return DIR_BACK;
        end
        return DIR_NONE;
    endfunction

endpackage
`default_nettype wire

/* sv/qec_step.sv */
// Next-state logic for one sample or load transaction.
`timescale 1ns / 1ps
`default_nettype none
module qec_step (
    input  qec_pkg::state_t              cur,
    input  qec_pkg::item_t               item,
    input  logic [qec_pkg::COUNT_W-1:0]  limit,
    output qec_pkg::state_t              nxt
);
    import qec_pkg::*;

    logic [1:0]       now_pins;
    logic [1:0]       dir;
    logic [ACC_W:0]   acc_step;
    logic [COUNT_W-1:0] count_step;

    assign now_pins = {item.pin_b, item.pin_a};
    assign dir      = step_dir(cur.prev_pins, now_pins);

    always_comb begin
        nxt = cur;
        acc_step   = {1'b0, cur.acc};
        count_step = cur.count;
        if (item.cmd == CMD_LOAD) begin
            nxt.count = item.load_value;
        end else begin
            unique case (dir)
                DIR_FWD:  acc_step = {1'b0, cur.acc} + {{ACC_W{1'b0}}, 1'b1};
                DIR_BACK: acc_step = {1'b0, cur.acc} - {{ACC_W{1'b0}}, 1'b1};
                default:  acc_step = {1'b0, cur.acc};
            endcase
            nxt.acc = acc_step[ACC_W-1:0];
            // Full detent either way: move the count and drop back to rest.
            if (acc_step[ACC_W]) begin
                count_step = cur.count + {{(COUNT_W-1){1'b0}}, 1'b1};
                nxt.acc    = ACC_REST;
            end else if (acc_step == '0) begin
                count_step = cur.count - {{(COUNT_W-1){1'b0}}, 1'b1};
                nxt.acc    = ACC_REST;
            end
            nxt.count     = (count_step >= limit) ? '0 : count_step;
            nxt.prev_pins = now_pins;
        end
    end

endmodule
`default_nettype wire

/* sv/quadrature_encoder_counter.sv */
// A transaction accepted into the input register moves on to the result register once that is free or draining.
// Throughput: one transaction per cycle unless a held result stalls it; the state update sits between the
// input register and the result register, so the state loop passes through state_reg alone.
// Reset: count 0, sub-step 4, previous pins 0, count_limit 60000, both stages empty.
// A held result stalls the input register, which then holds one more transaction.
`timescale 1ns / 1ps
`default_nettype none
`include "quadrature_encoder_counter_macros.svh"
module quadrature_encoder_counter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [qec_pkg::COUNT_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic                         pin_a,
    input  logic                         pin_b,
    input  logic [qec_pkg::COUNT_W-1:0]  load_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [qec_pkg::COUNT_W-1:0]  count,
    output logic [qec_pkg::ACC_W-1:0]    sub_step
);
    import qec_pkg::*;

    logic [COUNT_W-1:0] count_limit_reg;
    logic               in_valid_reg;
    item_t              in_item_reg;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [ACC_W-1:0]   out_sub_step_reg;
    state_t             state_reg;
    state_t             state_next;
    logic               advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_limit_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            count_limit_reg <= cfg_data;
        end
    end

    // Move the held transaction on when the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            in_item_reg <= '{cmd: cmd, pin_a: pin_a, pin_b: pin_b, load_value: load_value};
        end
    end

    qec_step u_step (
        .cur   (state_reg),
        .item  (in_item_reg),
        .limit (count_limit_reg),
        .nxt   (state_next)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= '{prev_pins: 2'd0, acc: ACC_REST, count: '0};
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            out_count_reg    <= state_next.count;
            out_sub_step_reg <= state_next.acc;
        end
    end

    assign out_valid = out_valid_reg;
    assign count     = out_count_reg;
    assign sub_step  = out_sub_step_reg;

    `QEC_ASSERT(a_acc_never_zero, state_reg.acc != '0, "sub-step accumulator reached zero at rest")
    `QEC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg,
        "advanced transaction did not reach the result register")
    `QEC_ASSERT_NEXT(a_load_sets_count, advance && in_item_reg.cmd == CMD_LOAD,
        state_reg.count == $past(in_item_reg.load_value), "load did not set the count")
    `QEC_ASSERT_NEXT(a_stall_holds_input, in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg), "stalled input register changed")

endmodule
`default_nettype wire
